// ===== sv/lia_pkg.sv =====
// shared constants for the look-ahead first-order iir filter
// register indexes and coefficient reset values; no dependencies
package lia_pkg;

  // width of the configuration register index
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_B0 = 3'd0,
    REG_C0 = 3'd1,
    REG_C1 = 3'd2,
    REG_C2 = 3'd3
  } cfg_reg_e;

  // coefficients derived from b0 = 430, b1 = 430, a1 = -163 at 2^-10 scale
  localparam int CoefB0Rst = 430;
  localparam int CoefC0Rst = 499;
  localparam int CoefC1Rst = -69;
  localparam int CoefC2Rst = 25;

endpackage

// ===== sv/lia_coef.sv =====
// coefficient register bank, written through the configuration channel
// depends on lia_pkg for register indexes and reset values
module lia_coef #(
  parameter int unsigned DATA_WIDTH = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [lia_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [DATA_WIDTH-1:0]         wr_data_i,
  output logic signed [DATA_WIDTH-1:0]  coef_b0_o,
  output logic signed [DATA_WIDTH-1:0]  coef_c0_o,
  output logic signed [DATA_WIDTH-1:0]  coef_c1_o,
  output logic signed [DATA_WIDTH-1:0]  coef_c2_o
);
  import lia_pkg::*;

  logic signed [DATA_WIDTH-1:0] b0_q, c0_q, c1_q, c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= DATA_WIDTH'(CoefB0Rst);
      c0_q <= DATA_WIDTH'(CoefC0Rst);
      c1_q <= DATA_WIDTH'(CoefC1Rst);
      c2_q <= DATA_WIDTH'(CoefC2Rst);
    end else if (wr_en_i) begin
      // indexes past the last register are dropped
      case (wr_idx_i)
        REG_B0:  b0_q <= wr_data_i;
        REG_C0:  c0_q <= wr_data_i;
        REG_C1:  c1_q <= wr_data_i;
        REG_C2:  c2_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign coef_b0_o = b0_q;
  assign coef_c0_o = c0_q;
  assign coef_c1_o = c1_q;
  assign coef_c2_o = c2_q;

endmodule

// ===== sv/lia_core.sv =====
// filter state: node delay line, registered products and difference
// one sample per step enable; output word is formed from the current state
module lia_core #(
  parameter int unsigned DATA_WIDTH = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [DATA_WIDTH-1:0]         sample_i,
  input  logic signed [DATA_WIDTH-1:0]  coef_b0_i,
  input  logic signed [DATA_WIDTH-1:0]  coef_c0_i,
  input  logic signed [DATA_WIDTH-1:0]  coef_c1_i,
  input  logic signed [DATA_WIDTH-1:0]  coef_c2_i,
  output logic [DATA_WIDTH:0]           y_o
);
  localparam int unsigned IntW  = DATA_WIDTH + 1;
  localparam int unsigned ProdW = 2 * DATA_WIDTH + 1;

  logic signed [IntW-1:0] node_q [3];
  logic signed [IntW-1:0] fb_q;
  logic signed [IntW-1:0] b0_line_q [2];
  logic signed [IntW-1:0] c0_q, c1_q, diff_q;

  logic signed [IntW-1:0]  node_d, diff_d;
  logic signed [ProdW-1:0] prod_fb, prod_b0, prod_c0, prod_c1;

  assign node_d  = $signed({sample_i[DATA_WIDTH-1], sample_i}) + fb_q;
  assign prod_fb = coef_c2_i * node_q[0];
  assign prod_b0 = coef_b0_i * node_q[0];
  assign prod_c0 = coef_c0_i * node_q[1];
  assign prod_c1 = coef_c1_i * node_q[2];
  assign diff_d  = c0_q - c1_q;
  assign y_o     = diff_q + b0_line_q[1];

  // arithmetic shift by DATA_WIDTH-1 then wrap is a plain part-select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q[0]    <= '0;
      node_q[1]    <= '0;
      node_q[2]    <= '0;
      fb_q         <= '0;
      b0_line_q[0] <= '0;
      b0_line_q[1] <= '0;
      c0_q         <= '0;
      c1_q         <= '0;
      diff_q       <= '0;
    end else if (step_i) begin
      node_q[0]    <= node_d;
      node_q[1]    <= node_q[0];
      node_q[2]    <= node_q[1];
      fb_q         <= prod_fb[DATA_WIDTH-1 +: IntW];
      b0_line_q[0] <= prod_b0[DATA_WIDTH-1 +: IntW];
      b0_line_q[1] <= b0_line_q[0];
      c0_q         <= prod_c0[DATA_WIDTH-1 +: IntW];
      c1_q         <= prod_c1[DATA_WIDTH-1 +: IntW];
      diff_q       <= diff_d;
    end
  end

endmodule

// ===== sv/lookahead_iir_first_order_unit.sv =====
// top level of the look-ahead first-order iir filter with stream ports
// depends on lia_pkg, lia_coef and lia_core
//
// Takes one sample per clock and returns one filtered sample per input, in
// order. Each transfer loads the output register with the core output formed
// from the prior state; the output register lets a new sample in while the
// current result is taken in the same cycle, so the sustained rate is one
// sample per clock, limited only by the downstream tready. Coefficients are
// written through the cfg channel (index 0 b0, 1 c0, 2 c1, 3 c2; other
// indexes ignored) and should be changed only while the filter is idle.
module lookahead_iir_first_order_unit #(
  parameter int unsigned DATA_WIDTH = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_in
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample_out
  output logic [((DATA_WIDTH+8)/8)*8-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lia_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [DATA_WIDTH-1:0]             cfg_data_i
);
  import lia_pkg::*;

  localparam int unsigned OutW   = DATA_WIDTH + 1;
  localparam int unsigned OutPad = ((DATA_WIDTH + 8) / 8) * 8;

  logic signed [DATA_WIDTH-1:0] coef_b0, coef_c0, coef_c1, coef_c2;
  logic                         in_xfer;
  logic [OutW-1:0]              y;
  logic                         out_valid_q, out_valid_d;
  logic [OutW-1:0]              out_data_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  lia_coef #(.DATA_WIDTH(DATA_WIDTH)) u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .coef_b0_o (coef_b0),
    .coef_c0_o (coef_c0),
    .coef_c1_o (coef_c1),
    .coef_c2_o (coef_c2)
  );

  lia_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .sample_i  (s_axis_tdata[DATA_WIDTH-1:0]),
    .coef_b0_i (coef_b0),
    .coef_c0_i (coef_c0),
    .coef_c1_i (coef_c1),
    .coef_c2_i (coef_c2),
    .y_o       (y)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= y;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutPad'(out_data_q);

endmodule

// ===== sv/lia_checker.sv =====
// port-level checks for lookahead_iir_first_order_unit
// bound to the top level; no package dependency
module lia_checker #(
  parameter int unsigned DATA_WIDTH = 11
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((DATA_WIDTH+8)/8)*8-1:0]   m_axis_tdata
);

  // a result is offered only after a sample transfer
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result offered without a sample transfer");

  // input side is open exactly when the output register frees up
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output register state");

  // every sample transfer leaves a result waiting in the next cycle
  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("sample transfer produced no result");

  // a pending result holds its data until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result dropped or changed");

endmodule

bind lookahead_iir_first_order_unit lia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_lia_checker (.*);
